>>> hdl/smpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the square marker pose check.
// Used by every module of the block; depends on nothing else.
package smpc_pkg;

  localparam int CoordBits = 10;
  localparam int EdgeW     = CoordBits + 1;      // signed vertex difference
  localparam int SqW       = 2 * CoordBits;      // square of one difference
  localparam int LenW      = 2 * CoordBits + 1;  // squared side length
  localparam int DotW      = 2 * CoordBits + 2;  // signed corner dot product
  localparam int ShoeW     = 2 * CoordBits + 3;  // signed doubled area
  localparam int AreaW     = 21;
  localparam int TolW      = 17;
  localparam int RatW      = 16;
  localparam int DistW     = 15;
  localparam int RotW      = 17;
  localparam int SqBits    = CoordBits + 5;      // root bits of the distance
  localparam int RadW      = 2 * SqBits;         // radicand and remainder
  localparam int XW        = CoordBits + 20;     // CORDIC vector components
  localparam int ZW        = 26;                 // CORDIC angle, Q.16 degrees
  localparam int AtanW     = 22;
  localparam int FrontStages = 8;

  localparam logic [AreaW-1:0] MinAreaRst = 21'd20000;
  localparam logic [AreaW-1:0] MaxAreaRst = 21'd25000;
  localparam logic [TolW-1:0]  CosTolRst  = 17'd1311;
  localparam logic [RatW-1:0]  RatTolRst  = 16'd1311;
  localparam logic [CoordBits-1:0] CamXRst = 10'd320;
  localparam logic [CoordBits-1:0] CamYRst = 10'd240;
  localparam logic [AreaW-1:0] AreaSat    = 21'h1FFFFF;
  localparam logic [TolW-1:0]  RatioOne   = 17'd65536;
  localparam logic signed [ZW-1:0] QuarterTurn = 26'sd5898240;  // 90 deg, Q.16
  localparam logic signed [ZW-1:0] RoundHalf   = 26'sd128;
  localparam logic signed [ZW-1:0] RotLimit    = 26'sd46080;

  typedef logic [CoordBits-1:0] coord_t;

  typedef enum logic [1:0] {
    VERDICT_SQUARE = 2'd0,
    VERDICT_SHAPE  = 2'd1,
    VERDICT_CORNER = 2'd2,
    VERDICT_RATIO  = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    REG_MIN_AREA  = 3'd0,
    REG_MAX_AREA  = 3'd1,
    REG_COS_TOL   = 3'd2,
    REG_RATIO_TOL = 3'd3,
    REG_CAM_X     = 3'd4,
    REG_CAM_Y     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [AreaW-1:0] min_area;
    logic [AreaW-1:0] max_area;
    logic [TolW-1:0]  cos_tol;
    logic [TolW-1:0]  ratio_hi;   // one plus the ratio tolerance, Q.16
    logic [TolW-1:0]  ratio_lo;   // one minus the ratio tolerance, Q.16
    coord_t           cam_x;
    coord_t           cam_y;
  } smpc_cfg_t;

  typedef struct packed {
    coord_t                  cx;
    coord_t                  cy;
    coord_t                  ax0;
    coord_t                  ay0;
    coord_t                  ax1;
    coord_t                  ay1;
    logic signed [EdgeW-1:0] dx;
    logic signed [EdgeW-1:0] dy;
  } smpc_pose_t;

  typedef struct packed {
    verdict_e             verdict;
    logic [AreaW-1:0]     area;
    coord_t               cx;
    coord_t               cy;
    coord_t               ax0;
    coord_t               ay0;
    coord_t               ax1;
    coord_t               ay1;
    logic                 zero_dir;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [RadW-1:0]      rem;
    logic [SqBits-1:0]    root;
  } smpc_iter_t;

  // atan(2^-i) in degrees, Q.16.
  function automatic logic [AtanW-1:0] atan_q16(input int unsigned idx);
    logic [AtanW-1:0] v;
    case (idx)
      0:  v = 22'd2949120;
      1:  v = 22'd1740967;
      2:  v = 22'd919879;
      3:  v = 22'd466945;
      4:  v = 22'd234379;
      5:  v = 22'd117304;
      6:  v = 22'd58666;
      7:  v = 22'd29335;
      8:  v = 22'd14668;
      9:  v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      20: v = 22'd4;
      21: v = 22'd2;
      22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/smpc_front.sv
`timescale 1ns / 1ps
// Front pipeline: area, corner and side ratio tests, centroid, axis and
// the CORDIC and square root set-up, in eight register stages. Uses smpc_pkg.
module smpc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [5:0]            count_i,
  input  smpc_pkg::coord_t [3:0] vx_i,
  input  smpc_pkg::coord_t [3:0] vy_i,
  input  smpc_pkg::smpc_cfg_t   cfg_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output smpc_pkg::smpc_iter_t  data_o
);
  import smpc_pkg::*;

  logic [FrontStages-1:0] v_q;
  logic [FrontStages-1:0] en;

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    en[FrontStages-1] = !v_q[FrontStages-1] || ready_i;
    for (int s = FrontStages - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[FrontStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int s = 1; s < FrontStages; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // Stage 1: capture.
  coord_t s1_x_q [4];
  coord_t s1_y_q [4];
  logic   s1_c4_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int k = 0; k < 4; k++) begin
        s1_x_q[k] <= vx_i[k];
        s1_y_q[k] <= vy_i[k];
      end
      s1_c4_q <= (count_i == 6'd4);
    end
  end

  // Stage 2: side vectors, shoelace products and coordinate sums.
  logic signed [EdgeW-1:0] s2_ex_q [4];
  logic signed [EdgeW-1:0] s2_ey_q [4];
  logic [SqW-1:0]          s2_pxy_q [4];
  logic [SqW-1:0]          s2_pyx_q [4];
  logic [CoordBits:0]      s2_mx_q [4];
  logic [CoordBits:0]      s2_my_q [4];
  logic [CoordBits+1:0]    s2_sx_q, s2_sy_q;
  logic                    s2_c4_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int k = 0; k < 4; k++) begin
        s2_ex_q[k]  <= $signed({1'b0, s1_x_q[(k+1)&3]}) - $signed({1'b0, s1_x_q[k]});
        s2_ey_q[k]  <= $signed({1'b0, s1_y_q[(k+1)&3]}) - $signed({1'b0, s1_y_q[k]});
        s2_pxy_q[k] <= SqW'(s1_x_q[k]) * SqW'(s1_y_q[(k+1)&3]);
        s2_pyx_q[k] <= SqW'(s1_x_q[(k+1)&3]) * SqW'(s1_y_q[k]);
        s2_mx_q[k]  <= {1'b0, s1_x_q[k]} + {1'b0, s1_x_q[(k+1)&3]};
        s2_my_q[k]  <= {1'b0, s1_y_q[k]} + {1'b0, s1_y_q[(k+1)&3]};
      end
      s2_sx_q <= (CoordBits+2)'(s1_x_q[0]) + (CoordBits+2)'(s1_x_q[1])
               + (CoordBits+2)'(s1_x_q[2]) + (CoordBits+2)'(s1_x_q[3]);
      s2_sy_q <= (CoordBits+2)'(s1_y_q[0]) + (CoordBits+2)'(s1_y_q[1])
               + (CoordBits+2)'(s1_y_q[2]) + (CoordBits+2)'(s1_y_q[3]);
      s2_c4_q <= s1_c4_q;
    end
  end

  // Stage 3: doubled signed area, squares and corner dot terms, centroid.
  logic signed [ShoeW-1:0] s3_shoe_q;
  logic [SqW-1:0]          s3_exx_q [4];
  logic [SqW-1:0]          s3_eyy_q [4];
  logic signed [SqW:0]     s3_dxx_q [4];
  logic signed [SqW:0]     s3_dyy_q [4];
  logic signed [EdgeW-1:0] s3_ex_q [2];
  logic signed [EdgeW-1:0] s3_ey_q [2];
  logic signed [EdgeW-1:0] s3_ddx_q, s3_ddy_q;
  coord_t                  s3_cx_q, s3_cy_q;
  coord_t                  s3_hx_q [4];
  coord_t                  s3_hy_q [4];
  logic                    s3_c4_q;

  logic signed [ShoeW-1:0] shoe_d;
  logic signed [2*EdgeW-1:0] exx_p [4], eyy_p [4], dxx_p [4], dyy_p [4];
  coord_t cx_d, cy_d;

  always_comb begin
    shoe_d = '0;
    for (int k = 0; k < 4; k++) begin
      shoe_d = shoe_d + $signed(ShoeW'(s2_pxy_q[k])) - $signed(ShoeW'(s2_pyx_q[k]));
      exx_p[k] = s2_ex_q[k] * s2_ex_q[k];
      eyy_p[k] = s2_ey_q[k] * s2_ey_q[k];
      dxx_p[k] = s2_ex_q[(k+3)&3] * s2_ex_q[k];
      dyy_p[k] = s2_ey_q[(k+3)&3] * s2_ey_q[k];
    end
    cx_d = s2_sx_q[CoordBits+1:2];
    cy_d = s2_sy_q[CoordBits+1:2];
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_shoe_q <= shoe_d;
      for (int k = 0; k < 4; k++) begin
        s3_exx_q[k] <= exx_p[k][SqW-1:0];
        s3_eyy_q[k] <= eyy_p[k][SqW-1:0];
        s3_dxx_q[k] <= dxx_p[k][SqW:0];
        s3_dyy_q[k] <= dyy_p[k][SqW:0];
        s3_hx_q[k]  <= s2_mx_q[k][CoordBits:1];
        s3_hy_q[k]  <= s2_my_q[k][CoordBits:1];
      end
      for (int k = 0; k < 2; k++) begin
        s3_ex_q[k] <= s2_ex_q[k];
        s3_ey_q[k] <= s2_ey_q[k];
      end
      s3_ddx_q <= $signed({1'b0, cx_d}) - $signed({1'b0, cfg_i.cam_x});
      s3_ddy_q <= $signed({1'b0, cy_d}) - $signed({1'b0, cfg_i.cam_y});
      s3_cx_q  <= cx_d;
      s3_cy_q  <= cy_d;
      s3_c4_q  <= s2_c4_q;
    end
  end

  // Stage 4: side lengths, dot products, base side choice.
  logic [ShoeW-1:0]        s4_s2_q;
  logic [LenW-1:0]         s4_len_q [4];
  logic signed [DotW-1:0]  s4_dot_q [4];
  logic [SqW-1:0]          s4_ddx2_q, s4_ddy2_q;
  smpc_pose_t              s4_pose_q;
  logic                    s4_c4_q;

  logic [LenW-1:0] len_d [4];
  logic signed [2*EdgeW-1:0] ddx2_p, ddy2_p;
  smpc_pose_t pose_d;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      len_d[k] = LenW'(s3_exx_q[k]) + LenW'(s3_eyy_q[k]);
    end
    ddx2_p = s3_ddx_q * s3_ddx_q;
    ddy2_p = s3_ddy_q * s3_ddy_q;
    pose_d.cx = s3_cx_q;
    pose_d.cy = s3_cy_q;
    // The longer of sides zero-one and one-two is the base.
    if (len_d[0] >= len_d[1]) begin
      pose_d.dx  = s3_ex_q[0];
      pose_d.dy  = s3_ey_q[0];
      pose_d.ax0 = s3_hx_q[1];
      pose_d.ay0 = s3_hy_q[1];
      pose_d.ax1 = s3_hx_q[3];
      pose_d.ay1 = s3_hy_q[3];
    end else begin
      pose_d.dx  = -s3_ex_q[1];
      pose_d.dy  = -s3_ey_q[1];
      pose_d.ax0 = s3_hx_q[0];
      pose_d.ay0 = s3_hy_q[0];
      pose_d.ax1 = s3_hx_q[2];
      pose_d.ay1 = s3_hy_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_s2_q <= s3_shoe_q[ShoeW-1] ? ShoeW'(-s3_shoe_q) : ShoeW'(s3_shoe_q);
      for (int k = 0; k < 4; k++) begin
        s4_len_q[k] <= len_d[k];
        s4_dot_q[k] <= DotW'(s3_dxx_q[k]) + DotW'(s3_dyy_q[k]);
      end
      s4_ddx2_q <= ddx2_p[SqW-1:0];
      s4_ddy2_q <= ddy2_p[SqW-1:0];
      s4_pose_q <= pose_d;
      s4_c4_q   <= s3_c4_q;
    end
  end

  // Stage 5: area window, first tolerance products.
  localparam int A1W = TolW + LenW;
  logic [LenW-1:0] s5_dm_q [4];
  logic [LenW-1:0] s5_len_q [4];
  logic [A1W-1:0]  s5_a1_q [4];
  logic [A1W-1:0]  s5_ra_q, s5_rb_q;
  logic            s5_fail_q;
  logic [AreaW-1:0] s5_area_q;
  logic [LenW-1:0] s5_dist2_q;
  smpc_pose_t      s5_pose_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int k = 0; k < 4; k++) begin
        s5_dm_q[k]  <= s4_dot_q[k][DotW-1] ? LenW'(-s4_dot_q[k]) : LenW'(s4_dot_q[k]);
        s5_len_q[k] <= s4_len_q[k];
        s5_a1_q[k]  <= A1W'(cfg_i.cos_tol) * A1W'(s4_len_q[(k+3)&3]);
      end
      s5_ra_q   <= A1W'(cfg_i.ratio_hi) * A1W'(s4_len_q[1]);
      s5_rb_q   <= A1W'(cfg_i.ratio_lo) * A1W'(s4_len_q[1]);
      s5_fail_q <= !s4_c4_q || !(s4_s2_q > ShoeW'({cfg_i.min_area, 1'b0}))
                   || !(s4_s2_q < ShoeW'({cfg_i.max_area, 1'b0}));
      s5_area_q <= (s4_s2_q[ShoeW-1:1] > (ShoeW-1)'(AreaSat)) ? AreaSat
                                                              : AreaW'(s4_s2_q[ShoeW-1:1]);
      s5_dist2_q <= LenW'(s4_ddx2_q) + LenW'(s4_ddy2_q);
      s5_pose_q  <= s4_pose_q;
    end
  end

  // Stage 6: squared dot products and second products.
  localparam int D2W = 2 * LenW;
  localparam int A2W = A1W + LenW;
  localparam int R2W = A1W + TolW;
  logic [D2W-1:0]  s6_d2_q [4];
  logic [A2W-1:0]  s6_a2_q [4];
  logic [R2W-1:0]  s6_ra2_q, s6_rb2_q;
  logic [LenW-1:0] s6_l0_q, s6_l1_q;
  logic            s6_fail_q;
  logic [AreaW-1:0] s6_area_q;
  logic [LenW-1:0] s6_dist2_q;
  smpc_pose_t      s6_pose_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int k = 0; k < 4; k++) begin
        s6_d2_q[k] <= D2W'(s5_dm_q[k]) * D2W'(s5_dm_q[k]);
        s6_a2_q[k] <= A2W'(s5_a1_q[k]) * A2W'(s5_len_q[k]);
      end
      s6_ra2_q   <= R2W'(s5_ra_q) * R2W'(cfg_i.ratio_hi);
      s6_rb2_q   <= R2W'(s5_rb_q) * R2W'(cfg_i.ratio_lo);
      s6_l0_q    <= s5_len_q[0];
      s6_l1_q    <= s5_len_q[1];
      s6_fail_q  <= s5_fail_q;
      s6_area_q  <= s5_area_q;
      s6_dist2_q <= s5_dist2_q;
      s6_pose_q  <= s5_pose_q;
    end
  end

  // Stage 7: last tolerance product, side ratio test.
  localparam int A3W = A2W + TolW;
  logic [A3W-1:0]  s7_a3_q [4];
  logic [D2W-1:0]  s7_d2_q [4];
  logic            s7_rfail_q;
  logic            s7_fail_q;
  logic [AreaW-1:0] s7_area_q;
  logic [LenW-1:0] s7_dist2_q;
  smpc_pose_t      s7_pose_q;

  logic [R2W-1:0] l0_sc;
  assign l0_sc = R2W'({s6_l0_q, 32'd0});

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      for (int k = 0; k < 4; k++) begin
        s7_a3_q[k] <= A3W'(s6_a2_q[k]) * A3W'(cfg_i.cos_tol);
        s7_d2_q[k] <= s6_d2_q[k];
      end
      s7_rfail_q <= (s6_l1_q == '0) || !(l0_sc < s6_ra2_q) || !(l0_sc > s6_rb2_q);
      s7_fail_q  <= s6_fail_q;
      s7_area_q  <= s6_area_q;
      s7_dist2_q <= s6_dist2_q;
      s7_pose_q  <= s6_pose_q;
    end
  end

  // Stage 8: corner test, verdict, CORDIC pre-rotation into the right half.
  logic                    cfail;
  verdict_e                verdict_d;
  logic signed [EdgeW-1:0] xi, yi;
  logic signed [ZW-1:0]    z0;
  smpc_iter_t              s8_q;

  always_comb begin
    cfail = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (A3W'({s7_d2_q[k], 32'd0}) > s7_a3_q[k]) begin
        cfail = 1'b1;
      end
    end
    if (s7_fail_q) begin
      verdict_d = VERDICT_SHAPE;
    end else if (cfail) begin
      verdict_d = VERDICT_CORNER;
    end else if (s7_rfail_q) begin
      verdict_d = VERDICT_RATIO;
    end else begin
      verdict_d = VERDICT_SQUARE;
    end
    xi = s7_pose_q.dx;
    yi = s7_pose_q.dy;
    z0 = '0;
    if (s7_pose_q.dx[EdgeW-1]) begin
      if (!s7_pose_q.dy[EdgeW-1]) begin
        xi = s7_pose_q.dy;
        yi = -s7_pose_q.dx;
        z0 = QuarterTurn;
      end else begin
        xi = -s7_pose_q.dy;
        yi = s7_pose_q.dx;
        z0 = -QuarterTurn;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s8_q.verdict  <= verdict_d;
      s8_q.area     <= s7_area_q;
      s8_q.cx       <= s7_pose_q.cx;
      s8_q.cy       <= s7_pose_q.cy;
      s8_q.ax0      <= s7_pose_q.ax0;
      s8_q.ay0      <= s7_pose_q.ay0;
      s8_q.ax1      <= s7_pose_q.ax1;
      s8_q.ay1      <= s7_pose_q.ay1;
      s8_q.zero_dir <= (s7_pose_q.dx == '0) && (s7_pose_q.dy == '0);
      s8_q.x        <= XW'(xi) <<< 16;
      s8_q.y        <= XW'(yi) <<< 16;
      s8_q.z        <= z0;
      s8_q.rem      <= RadW'({s7_dist2_q, 8'd0});
      s8_q.root     <= '0;
    end
  end

  assign data_o = s8_q;

endmodule

>>> hdl/smpc_iter_stage.sv
`timescale 1ns / 1ps
// One register stage of the angle and distance back end: a CORDIC
// vectoring step, one bit of the integer square root, or both. Uses smpc_pkg.
module smpc_iter_stage #(
  parameter int STEP         = 0,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  smpc_pkg::smpc_iter_t data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output smpc_pkg::smpc_iter_t data_o
);
  import smpc_pkg::*;

  localparam bit DoRot  = (STEP < CORDIC_STEPS);
  localparam bit DoSqrt = (STEP < SqBits);
  localparam int RootBit = DoSqrt ? (SqBits - 1 - STEP) : 0;
  localparam logic [AtanW-1:0] AtanStep = atan_q16(STEP);

  logic                 v_q;
  logic                 en;
  smpc_iter_t           d_q, nxt;
  logic signed [XW-1:0] xs, ys;
  logic [RadW:0]        trial;

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;
  assign data_o  = d_q;

  always_comb begin
    nxt   = data_i;
    xs    = data_i.x >>> STEP;
    ys    = data_i.y >>> STEP;
    trial = ((RadW+1)'(data_i.root) << (RootBit + 1)) + ((RadW+1)'(1) << (2 * RootBit));
    if (DoRot) begin
      if (!data_i.y[XW-1]) begin
        nxt.x = data_i.x + ys;
        nxt.y = data_i.y - xs;
        nxt.z = data_i.z + $signed(ZW'(AtanStep));
      end else begin
        nxt.x = data_i.x - ys;
        nxt.y = data_i.y + xs;
        nxt.z = data_i.z - $signed(ZW'(AtanStep));
      end
    end
    // Restoring square root: the remainder tracks radicand minus root squared.
    if (DoSqrt) begin
      if ({1'b0, data_i.rem} >= trial) begin
        nxt.rem  = data_i.rem - trial[RadW-1:0];
        nxt.root = data_i.root | (SqBits'(1) << RootBit);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q <= nxt;
    end
  end

endmodule

>>> hdl/square_marker_pose_check.sv
`timescale 1ns / 1ps
// Square marker pose check, top level: configuration registers, front
// pipeline, angle and distance stages and output register. Uses smpc_pkg.
//
// Usage:
//   Input channel: in_valid_i with the vertex count and four vertices; a word
//   is taken on a clock edge where in_valid_i is high and in_stall_o low.
//   Output channel: out_valid_o with the verdict, area and pose fields; the
//   receiver holds out_stall_i high to keep the word on the ports.
//   Throughput is one word per cycle while out_stall_i is low. A word passes
//   eight front stages for the shape tests, one stage per CORDIC step or
//   square root bit, whichever count is larger, and the output register.
//   Configuration registers are written through cfg_we_i, cfg_index_i and
//   cfg_data_i; the user writes them only while no word is in flight, which
//   the block does not enforce. Indexes 6 and 7 are ignored.
//   Reset empties every stage and loads the default register values.
//   A stall at the output fills the empty stages first and then raises
//   in_stall_o; no word is dropped or repeated.
module square_marker_pose_check #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  vertex_count_i,
  input  logic [9:0]  vertex_x0_i,
  input  logic [9:0]  vertex_y0_i,
  input  logic [9:0]  vertex_x1_i,
  input  logic [9:0]  vertex_y1_i,
  input  logic [9:0]  vertex_x2_i,
  input  logic [9:0]  vertex_y2_i,
  input  logic [9:0]  vertex_x3_i,
  input  logic [9:0]  vertex_y3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [20:0] polygon_area_o,
  output logic [9:0]  centroid_x_o,
  output logic [9:0]  centroid_y_o,
  output logic [14:0] center_distance_o,
  output logic signed [16:0] rotation_degrees_o,
  output logic [9:0]  axis_start_x_o,
  output logic [9:0]  axis_start_y_o,
  output logic [9:0]  axis_end_x_o,
  output logic [9:0]  axis_end_y_o
);
  import smpc_pkg::*;

  localparam int NIter = (CORDIC_STEPS > SqBits) ? CORDIC_STEPS : SqBits;

  // Configuration registers.
  logic [AreaW-1:0] min_area_q, max_area_q;
  logic [TolW-1:0]  cos_tol_q;
  logic [RatW-1:0]  ratio_tol_q;
  coord_t           cam_x_q, cam_y_q;
  smpc_cfg_t        cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_area_q  <= MinAreaRst;
      max_area_q  <= MaxAreaRst;
      cos_tol_q   <= CosTolRst;
      ratio_tol_q <= RatTolRst;
      cam_x_q     <= CamXRst;
      cam_y_q     <= CamYRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MIN_AREA:  min_area_q  <= cfg_data_i;
        REG_MAX_AREA:  max_area_q  <= cfg_data_i;
        REG_COS_TOL:   cos_tol_q   <= cfg_data_i[TolW-1:0];
        REG_RATIO_TOL: ratio_tol_q <= cfg_data_i[RatW-1:0];
        REG_CAM_X:     cam_x_q     <= cfg_data_i[CoordBits-1:0];
        REG_CAM_Y:     cam_y_q     <= cfg_data_i[CoordBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.min_area = min_area_q;
    cfg.max_area = max_area_q;
    cfg.cos_tol  = cos_tol_q;
    cfg.ratio_hi = RatioOne + TolW'(ratio_tol_q);
    cfg.ratio_lo = RatioOne - TolW'(ratio_tol_q);
    cfg.cam_x    = cam_x_q;
    cfg.cam_y    = cam_y_q;
  end

  // Front pipeline.
  coord_t [3:0] vx, vy;
  assign vx = {vertex_x3_i, vertex_x2_i, vertex_x1_i, vertex_x0_i};
  assign vy = {vertex_y3_i, vertex_y2_i, vertex_y1_i, vertex_y0_i};

  logic       front_ready;
  logic       iter_v   [NIter+1];
  logic       iter_rdy [NIter+1];
  smpc_iter_t iter_d   [NIter+1];

  smpc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .count_i (vertex_count_i),
    .vx_i    (vx),
    .vy_i    (vy),
    .cfg_i   (cfg),
    .valid_o (iter_v[0]),
    .ready_i (iter_rdy[0]),
    .data_o  (iter_d[0])
  );

  assign in_stall_o = !front_ready;

  for (genvar g = 0; g < NIter; g++) begin : g_iter
    smpc_iter_stage #(
      .STEP         (g),
      .CORDIC_STEPS (CORDIC_STEPS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (iter_v[g]),
      .ready_o (iter_rdy[g]),
      .data_i  (iter_d[g]),
      .valid_o (iter_v[g+1]),
      .ready_i (iter_rdy[g+1]),
      .data_o  (iter_d[g+1])
    );
  end

  // Output register: rounding, clamping, and clearing of non-square pose.
  logic                 out_en;
  logic                 out_v_q;
  smpc_iter_t           last;
  logic                 square;
  logic signed [ZW-1:0] rot_r;
  logic signed [ZW-1:0] rot_c;

  assign out_en = !out_v_q || !out_stall_i;
  assign iter_rdy[NIter] = out_en;
  assign last = iter_d[NIter];
  assign square = (last.verdict == VERDICT_SQUARE);

  always_comb begin
    rot_r = (last.z + RoundHalf) >>> 8;
    rot_c = rot_r;
    if (rot_r > RotLimit) begin
      rot_c = RotLimit;
    end else if (rot_r < -RotLimit) begin
      rot_c = -RotLimit;
    end
    if (last.zero_dir) begin
      rot_c = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= iter_v[NIter];
    end
  end

  // The root is at most 15 bits wide, so the distance never needs clipping.
  always_ff @(posedge clk_i) begin
    if (out_en) begin
      verdict_o          <= last.verdict;
      polygon_area_o     <= last.area;
      centroid_x_o       <= square ? last.cx : '0;
      centroid_y_o       <= square ? last.cy : '0;
      center_distance_o  <= square ? DistW'(last.root) : '0;
      rotation_degrees_o <= square ? RotW'(rot_c) : '0;
      axis_start_x_o     <= square ? last.ax0 : '0;
      axis_start_y_o     <= square ? last.ay0 : '0;
      axis_end_x_o       <= square ? last.ax1 : '0;
      axis_end_y_o       <= square ? last.ay1 : '0;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

>>> hdl/smpc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the square marker pose check, bound to the top
// level below. Uses smpc_pkg for the verdict codes.
module smpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  verdict_o,
  input logic [20:0] polygon_area_o,
  input logic [9:0]  centroid_x_o,
  input logic [14:0] center_distance_o,
  input logic signed [16:0] rotation_degrees_o,
  input logic [9:0]  axis_end_x_o
);
  import smpc_pkg::*;

  // Back-pressure only ever starts at a blocked output word.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output word");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_word_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(verdict_o) && $stable(polygon_area_o) && $stable(rotation_degrees_o)))
    else $error("output word changed while stalled");

  // A rejected polygon carries no pose.
  a_reject_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (verdict_o != VERDICT_SQUARE)) |->
      ((centroid_x_o == '0) && (center_distance_o == '0)
       && (rotation_degrees_o == '0) && (axis_end_x_o == '0)))
    else $error("pose fields set on a rejected polygon");

endmodule

bind square_marker_pose_check smpc_checker u_smpc_checker (.*);

>>> verif/square_marker_pose_check_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for square_marker_pose_check: directed polygons,
// then random squares, rectangles and noise over several register settings.
// Depends on smpc_pkg and the square_marker_pose_check RTL.
module square_marker_pose_check_test;
  import smpc_pkg::*;

  localparam int Latency = 25;
  localparam int CycleLimit = 500000;

  typedef struct {
    logic [5:0] cnt;
    coord_t     x[4];
    coord_t     y[4];
  } polygon_t;

  typedef struct packed {
    verdict_e          verdict;
    logic [20:0]       area;
    coord_t            cx;
    coord_t            cy;
    logic [14:0]       distance;
    logic signed [16:0] rot;
    coord_t            ax0;
    coord_t            ay0;
    coord_t            ax1;
    coord_t            ay1;
  } pose_t;

  typedef struct packed {
    logic [5:0] cnt;
    coord_t     x0, y0, x1, y1, x2, y2, x3, y3;
    logic       pinned;
    verdict_e   verdict;
  } shape_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [20:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [5:0] vertex_count_i = '0;
  logic [9:0] vertex_x0_i = '0, vertex_y0_i = '0, vertex_x1_i = '0, vertex_y1_i = '0;
  logic [9:0] vertex_x2_i = '0, vertex_y2_i = '0, vertex_x3_i = '0, vertex_y3_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] verdict_o;
  logic [20:0] polygon_area_o;
  logic [9:0] centroid_x_o, centroid_y_o;
  logic [14:0] center_distance_o;
  logic signed [16:0] rotation_degrees_o;
  logic [9:0] axis_start_x_o, axis_start_y_o, axis_end_x_o, axis_end_y_o;

  square_marker_pose_check u_dut (.*);

  always #10 clk_i = ~clk_i;

  // Register copies for the pose predictor.
  logic [20:0] min_area_q, max_area_q;
  logic [16:0] cos_tol_q;
  logic [15:0] ratio_tol_q;
  coord_t cam_x_q, cam_y_q;

  pose_t pending_poses[$];
  int mismatches = 0;
  int cycles = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;

  const longint AtanDeg[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                229, 115};

  function automatic pose_t predict_pose(polygon_t pg);
    longint x[4], y[4];
    longint sum, s2, area, ax, ay, bx, by, ex, ey, fx, fy, dx, dy;
    longint ddx, ddy, cx, cy, cxr, cyr, cz, xs, ys, r;
    longint unsigned dm, n12, tol2, a, b, hi, lo, rad, root, t;
    logic [127:0] lhs, rhs;
    pose_t res;
    int p, n;
    res = '0;
    for (int k = 0; k < 4; k++) begin
      x[k] = pg.x[k];
      y[k] = pg.y[k];
    end
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      n = (k + 1) % 4;
      sum += x[k] * y[n] - x[n] * y[k];
    end
    s2 = sum < 0 ? -sum : sum;
    area = s2 >> 1;
    res.area = area > 64'h1FFFFF ? 21'h1FFFFF : area[20:0];
    res.verdict = VERDICT_SQUARE;
    if (pg.cnt != 6'd4 || !(s2 > 2 * longint'(min_area_q)) ||
        !(s2 < 2 * longint'(max_area_q)))
      res.verdict = VERDICT_SHAPE;
    if (res.verdict == VERDICT_SQUARE) begin
      tol2 = longint'(cos_tol_q) * longint'(cos_tol_q);
      for (int k = 0; k < 4; k++) begin
        p = (k + 3) % 4;
        n = (k + 1) % 4;
        ax = x[p] - x[k]; ay = y[p] - y[k];
        bx = x[n] - x[k]; by = y[n] - y[k];
        dm = (ax * bx + ay * by) < 0 ? -(ax * bx + ay * by) : (ax * bx + ay * by);
        n12 = (ax * ax + ay * ay) * (bx * bx + by * by);
        lhs = (128'(dm) * 128'(dm)) << 32;
        rhs = 128'(tol2) * 128'(n12);
        if (lhs > rhs && res.verdict == VERDICT_SQUARE) res.verdict = VERDICT_CORNER;
      end
    end
    ex = x[0] - x[1]; ey = y[0] - y[1];
    fx = x[1] - x[2]; fy = y[1] - y[2];
    a = ex * ex + ey * ey;
    b = fx * fx + fy * fy;
    if (res.verdict == VERDICT_SQUARE) begin
      hi = 65536 + longint'(ratio_tol_q);
      lo = 65536 - longint'(ratio_tol_q);
      if (b == 0 || !((a << 32) < hi * hi * b) || !((a << 32) > lo * lo * b))
        res.verdict = VERDICT_RATIO;
    end
    if (res.verdict != VERDICT_SQUARE) return res;

    cx = (x[0] + x[1] + x[2] + x[3]) / 4;
    cy = (y[0] + y[1] + y[2] + y[3]) / 4;
    res.cx = cx[9:0];
    res.cy = cy[9:0];
    ddx = cx - longint'(cam_x_q);
    ddy = cy - longint'(cam_y_q);
    rad = (ddx * ddx + ddy * ddy) << 8;
    root = 0;
    for (int bit_i = 20; bit_i >= 0; bit_i--) begin
      t = root | (64'd1 << bit_i);
      if (t * t <= rad) root = t;
    end
    res.distance = root > 32767 ? 15'd32767 : root[14:0];
    if (a >= b) begin
      dx = x[1] - x[0]; dy = y[1] - y[0];
      res.ax0 = coord_t'((x[1] + x[2]) / 2); res.ay0 = coord_t'((y[1] + y[2]) / 2);
      res.ax1 = coord_t'((x[3] + x[0]) / 2); res.ay1 = coord_t'((y[3] + y[0]) / 2);
    end else begin
      dx = x[1] - x[2]; dy = y[1] - y[2];
      res.ax0 = coord_t'((x[0] + x[1]) / 2); res.ay0 = coord_t'((y[0] + y[1]) / 2);
      res.ax1 = coord_t'((x[2] + x[3]) / 2); res.ay1 = coord_t'((y[2] + y[3]) / 2);
    end
    // Vector rotation toward the positive x axis, angle in Q.16 degrees.
    cz = 0;
    if (!(dx == 0 && dy == 0)) begin
      if (dx < 0) begin
        if (dy >= 0) begin cxr = dy; cyr = -dx; cz = 90 * 65536; end
        else begin cxr = -dy; cyr = dx; cz = -90 * 65536; end
      end else begin
        cxr = dx; cyr = dy;
      end
      cxr *= 65536;
      cyr *= 65536;
      for (int i = 0; i < 16; i++) begin
        xs = cxr >>> i;
        ys = cyr >>> i;
        if (cyr >= 0) begin cxr += ys; cyr -= xs; cz += AtanDeg[i]; end
        else begin cxr -= ys; cyr += xs; cz -= AtanDeg[i]; end
      end
    end
    r = (cz + 128) >>> 8;
    if (r > 46080) r = 46080;
    if (r < -46080) r = -46080;
    res.rot = r[16:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("square_marker_pose_check_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // Result checker; reads pre-edge values of the registered outputs.
  always @(posedge clk_i) begin
    pose_t seen, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{verdict_e'(verdict_o), polygon_area_o, centroid_x_o, centroid_y_o,
               center_distance_o, rotation_degrees_o, axis_start_x_o,
               axis_start_y_o, axis_end_x_o, axis_end_y_o};
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", seen);
      end else begin
        want = pending_poses.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, seen);
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [20:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MIN_AREA:  min_area_q = data;
      REG_MAX_AREA:  max_area_q = data;
      REG_COS_TOL:   cos_tol_q = data[16:0];
      REG_RATIO_TOL: ratio_tol_q = data[15:0];
      REG_CAM_X:     cam_x_q = data[9:0];
      REG_CAM_Y:     cam_y_q = data[9:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  // Offers one word and returns at the edge that takes it.
  task automatic send_polygon(polygon_t pg, logic pinned, verdict_e pin_verdict);
    logic stalled;
    pose_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_count_i <= pg.cnt;
    vertex_x0_i <= pg.x[0]; vertex_y0_i <= pg.y[0];
    vertex_x1_i <= pg.x[1]; vertex_y1_i <= pg.y[1];
    vertex_x2_i <= pg.x[2]; vertex_y2_i <= pg.y[2];
    vertex_x3_i <= pg.x[3]; vertex_y3_i <= pg.y[3];
    // Inputs only move at the rising edge, so the stall seen at the falling
    // edge is the one the next rising edge acts on.
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    want = predict_pose(pg);
    if (pinned) want.verdict = pin_verdict;
    pending_poses.push_back(want);
  endtask

  function automatic polygon_t random_polygon();
    polygon_t pg, tmp;
    int cx, cy, m, rad, u, v, num, rot_start;
    int px[4], py[4];
    if ($urandom_range(99) < 20) begin
      pg.cnt = $urandom_range(99) < 50 ? 6'd4 : 6'($urandom);
      for (int k = 0; k < 4; k++) begin
        pg.x[k] = coord_t'($urandom);
        pg.y[k] = coord_t'($urandom);
      end
      return pg;
    end
    cx = $urandom_range(983, 40);
    cy = $urandom_range(983, 40);
    m = cx;
    if (cy < m) m = cy;
    if (1023 - cx < m) m = 1023 - cx;
    if (1023 - cy < m) m = 1023 - cy;
    rad = (m - 3) * 8 / 10;
    if (rad > 300) rad = 300;
    u = $urandom_range(2 * rad) - rad;
    v = $urandom_range(2 * rad) - rad;
    // Mostly squares; the rest are rectangles with one side scaled.
    num = $urandom_range(99) < 70 ? 8 : $urandom_range(10, 6);
    px[0] = cx + u;              py[0] = cy + v;
    px[1] = cx - v * num / 8;    py[1] = cy + u * num / 8;
    px[2] = cx - u;              py[2] = cy - v;
    px[3] = cx + v * num / 8;    py[3] = cy - u * num / 8;
    for (int k = 0; k < 4; k++) begin
      tmp.x[k] = coord_t'(px[k] + $urandom_range(2));
      tmp.y[k] = coord_t'(py[k] + $urandom_range(2));
    end
    rot_start = $urandom_range(3);
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(1) == 0 && k == 0) begin
        for (int j = 0; j < 4; j++) begin
          pg.x[j] = tmp.x[(rot_start + 4 - j) % 4];
          pg.y[j] = tmp.y[(rot_start + 4 - j) % 4];
        end
        break;
      end
      pg.x[k] = tmp.x[(rot_start + k) % 4];
      pg.y[k] = tmp.y[(rot_start + k) % 4];
    end
    pg.cnt = $urandom_range(99) < 95 ? 6'd4 : 6'($urandom_range(63));
    return pg;
  endfunction

  const shape_row_t DirectedShapes[17] = '{
    '{6'd0,  10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, VERDICT_SHAPE},
    '{6'd63, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
      10'd1023, 1'b1, VERDICT_SHAPE},
    '{6'd4, 10'd0, 10'd0, 10'd150, 10'd0, 10'd150, 10'd150, 10'd0, 10'd150,
      1'b1, VERDICT_SQUARE},
    '{6'd3, 10'd0, 10'd0, 10'd150, 10'd0, 10'd150, 10'd150, 10'd0, 10'd150,
      1'b1, VERDICT_SHAPE},
    '{6'd5, 10'd0, 10'd0, 10'd150, 10'd0, 10'd150, 10'd150, 10'd0, 10'd150,
      1'b1, VERDICT_SHAPE},
    '{6'd4, 10'd0, 10'd0, 10'd141, 10'd0, 10'd141, 10'd141, 10'd0, 10'd141,
      1'b1, VERDICT_SHAPE},
    '{6'd4, 10'd0, 10'd0, 10'd100, 10'd0, 10'd100, 10'd200, 10'd0, 10'd200,
      1'b1, VERDICT_SHAPE},
    '{6'd4, 10'd0, 10'd0, 10'd100, 10'd0, 10'd100, 10'd250, 10'd0, 10'd250,
      1'b1, VERDICT_SHAPE},
    '{6'd4, 10'd0, 10'd0, 10'd125, 10'd0, 10'd125, 10'd190, 10'd0, 10'd190,
      1'b1, VERDICT_RATIO},
    '{6'd4, 10'd0, 10'd0, 10'd150, 10'd0, 10'd180, 10'd150, 10'd30, 10'd150,
      1'b1, VERDICT_CORNER},
    '{6'd4, 10'd0, 10'd0, 10'd0, 10'd0, 10'd150, 10'd150, 10'd0, 10'd150,
      1'b0, VERDICT_SQUARE},
    '{6'd4, 10'd200, 10'd90, 10'd310, 10'd200, 10'd200, 10'd310, 10'd90, 10'd200,
      1'b0, VERDICT_SQUARE},
    '{6'd4, 10'd90, 10'd200, 10'd200, 10'd310, 10'd310, 10'd200, 10'd200, 10'd90,
      1'b0, VERDICT_SQUARE},
    '{6'd4, 10'd873, 10'd873, 10'd1023, 10'd873, 10'd1023, 10'd1023, 10'd873, 10'd1023,
      1'b0, VERDICT_SQUARE},
    '{6'd4, 10'd0, 10'd0, 10'd150, 10'd0, 10'd150, 10'd151, 10'd0, 10'd151,
      1'b0, VERDICT_SQUARE},
    '{6'd4, 10'd245, 10'd165, 10'd395, 10'd165, 10'd395, 10'd315, 10'd245, 10'd315,
      1'b0, VERDICT_SQUARE},
    '{6'd4, 10'd150, 10'd0, 10'd0, 10'd0, 10'd0, 10'd150, 10'd150, 10'd150,
      1'b0, VERDICT_SQUARE}
  };

  initial begin
    polygon_t pg;
    int n_items;
    min_area_q = MinAreaRst;
    max_area_q = MaxAreaRst;
    cos_tol_q = CosTolRst;
    ratio_tol_q = RatTolRst;
    cam_x_q = CamXRst;
    cam_y_q = CamYRst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedShapes[i]) begin
      pg.cnt = DirectedShapes[i].cnt;
      pg.x = '{DirectedShapes[i].x0, DirectedShapes[i].x1, DirectedShapes[i].x2,
               DirectedShapes[i].x3};
      pg.y = '{DirectedShapes[i].y0, DirectedShapes[i].y1, DirectedShapes[i].y2,
               DirectedShapes[i].y3};
      send_polygon(pg, DirectedShapes[i].pinned, DirectedShapes[i].verdict);
    end

    for (int ph = 0; ph < 5; ph++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      case (ph)
        0: begin
          write_reg(REG_MIN_AREA, 21'd0);
          write_reg(REG_MAX_AREA, 21'h1FFFFF);
          write_reg(REG_COS_TOL, 21'd65536);
          write_reg(REG_RATIO_TOL, 21'd65535);
          write_reg(REG_CAM_X, 21'd0);
          write_reg(REG_CAM_Y, 21'd0);
          sender_idle_pct = 0; stall_pct = 0; n_items = 200;
        end
        1: begin
          write_reg(REG_MIN_AREA, 21'h1FFFFF);
          write_reg(REG_MAX_AREA, 21'd0);
          write_reg(REG_COS_TOL, 21'd0);
          write_reg(REG_RATIO_TOL, 21'd0);
          write_reg(REG_CAM_X, 21'd1023);
          write_reg(REG_CAM_Y, 21'd1023);
          sender_idle_pct = 82; stall_pct = 0; n_items = 30;
        end
        default: begin
          write_reg(REG_MIN_AREA, 21'($urandom_range(3000)));
          write_reg(REG_MAX_AREA, 21'd1048576);
          write_reg(REG_COS_TOL, 21'(ph == 4 ? $urandom_range(1500) :
                                      $urandom_range(3000, 600)));
          write_reg(REG_RATIO_TOL, 21'($urandom_range(6000, 600)));
          write_reg(REG_CAM_X, 21'($urandom_range(1023)));
          write_reg(REG_CAM_Y, 21'($urandom_range(1023)));
          sender_idle_pct = ph == 3 ? 37 : (ph == 4 ? 82 : 0);
          stall_pct = ph == 4 ? 0 : (ph == 3 ? 37 : 82);
          n_items = 300;
        end
      endcase
      for (int i = 0; i < n_items; i++) begin
        // Let the pipeline run dry once mid-phase.
        if (ph == 2 && i == 150) begin
          in_valid_i <= 1'b0;
          while (pending_poses.size() != 0) @(posedge clk_i);
        end
        send_polygon(random_polygon(), 1'b0, VERDICT_SQUARE);
      end
    end
    in_valid_i <= 1'b0;
    stall_pct = 0;
    wait_drained();
    if (mismatches == 0 && pending_poses.size() == 0) begin
      $display("square_marker_pose_check_test: PASS");
    end else begin
      $display("square_marker_pose_check_test: FAIL");
    end
    $finish;
  end

endmodule
